>>> design/mdl_pkg.sv
// shared types and constants for the midpoint displacement line block
package mdl_pkg;

   localparam int COORD_W = 16;
   localparam int LVL_W   = 3;
   localparam int DEN_W   = 15;
   localparam int PROD_W  = 24;
   localparam int MAG_W   = 23;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   localparam logic KIND_MOVE = 1'b0;
   localparam logic KIND_LINE = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
      logic [LVL_W-1:0]          lvl;
   } seg_type;

   typedef struct packed {
      logic             start;
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [COORD_W-1:0] quo;
   } div_rsp_type;

endpackage

>>> design/midpoint_displacement_line_top.sv
// top level of the midpoint displacement fractal line generator
//
//   channel  dir  ports                                       role
//   req_*    in   command, endpoints, divisor, depth, step,   load or draw transaction
//                 table_index, table_value
//   rsp_*    out  point_kind, point_x, point_y, last           one point or load ack
//
// a load takes one transaction in and one ack out
// a draw runs two passes of the shared divider per node, up to 31 nodes at depth 5
// synchronous active-high reset clears control state and the table valid bits
// req_stall is high from acceptance until the last point sits in the output register
// rsp_stall holds the engine only when a new point is ready and the register is full
module midpoint_displacement_line_top #(
   parameter int TABLE_DEPTH = 256,
   parameter int MAX_DEPTH   = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   input  logic signed [15:0] req_end_x,
   input  logic signed [15:0] req_end_y,
   input  logic [14:0] req_divisor,
   input  logic [2:0]  req_depth,
   input  logic [15:0] req_jitter_step,
   input  logic [$clog2(TABLE_DEPTH)-1:0] req_table_index,
   input  logic signed [7:0] req_table_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_point_kind,
   output logic signed [15:0] rsp_point_x,
   output logic signed [15:0] rsp_point_y,
   output logic        rsp_last
);
   import mdl_pkg::*;

   localparam int TBL_AW = $clog2(TABLE_DEPTH);
   localparam int STK_D  = MAX_DEPTH;
   localparam int STK_AW = (STK_D > 1) ? $clog2(STK_D) : 1;
   localparam int SP_W   = $clog2(STK_D + 1);

   // sequencer states, one-hot
   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_ACK   = 14'b00000000000010,
      ST_MOVE  = 14'b00000000000100,
      ST_READ  = 14'b00000000001000,
      ST_JIT   = 14'b00000000010000,
      ST_MULA  = 14'b00000000100000,
      ST_STA   = 14'b00000001000000,
      ST_WAITA = 14'b00000010000000,
      ST_MULB  = 14'b00000100000000,
      ST_STB   = 14'b00001000000000,
      ST_WAITB = 14'b00010000000000,
      ST_MID   = 14'b00100000000000,
      ST_EMID  = 14'b01000000000000,
      ST_EEND  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   // jitter table, valid bits give the all-zero reset
   logic signed [7:0]      table_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] tvld_ff;
   logic signed [7:0]      trd_ff;
   logic                   trd_vld_ff;

   logic [15:0]         pos_ff, pos_in;
   logic [15:0]         step_ff, step_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   seg_type             cur_ff, cur_in;
   seg_type             stack_ff [STK_D];
   logic [SP_W-1:0]     sp_ff, sp_in;
   logic [SP_W-1:0]     sp_dec;
   logic                push;

   logic signed [7:0]         jit_ff, jit_in;
   logic signed [COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  prod_neg;
   logic signed [COORD_W-1:0] qa_ff, qa_in, qb_ff, qb_in;
   logic signed [COORD_W-1:0] mx, my;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      kind_ff, kind_in, last_ff, last_in;
   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic                      out_free, emit;

   logic req_take;
   logic [LVL_W-1:0] lvl_sat;

   mdl_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sp_dec    = sp_ff - 1'b1;

   assign lvl_sat = (req_depth > LVL_W'(MAX_DEPTH)) ? LVL_W'(MAX_DEPTH) : req_depth;

   // midpoint with perpendicular displacement, wraps to 16 bits
   assign mx = cur_ff.x1 + (dx_ff >>> 1) + qa_ff;
   assign my = cur_ff.y1 + (dy_ff >>> 1) - qb_ff;

   assign prod_neg = -prod_ff;

   always_comb begin
      div_req.start = (state_ff == ST_STA) || (state_ff == ST_STB);
      div_req.neg   = prod_ff[PROD_W-1];
      div_req.mag   = prod_ff[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod_ff[MAG_W-1:0];
      div_req.den   = den_ff;
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      step_in  = step_ff;
      den_in   = den_ff;
      cur_in   = cur_ff;
      sp_in    = sp_ff;
      push     = 1'b0;
      jit_in   = jit_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      prod_in  = prod_ff;
      qa_in    = qa_ff;
      qb_in    = qb_ff;
      emit     = 1'b0;
      kind_in  = kind_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      last_in  = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_command == CMD_LOAD) begin
                  state_in = ST_ACK;
               end else begin
                  cur_in.x1 = req_start_x;
                  cur_in.y1 = req_start_y;
                  cur_in.x2 = req_end_x;
                  cur_in.y2 = req_end_y;
                  cur_in.lvl = lvl_sat;
                  den_in   = (req_divisor == '0) ? DEN_W'(1) : req_divisor;
                  step_in  = req_jitter_step;
                  sp_in    = '0;
                  state_in = ST_MOVE;
               end
            end
         end
         ST_ACK: begin
            if (out_free) begin
               emit     = 1'b1;
               kind_in  = KIND_MOVE;
               px_in    = '0;
               py_in    = '0;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MOVE: begin
            if (out_free) begin
               emit     = 1'b1;
               kind_in  = KIND_MOVE;
               px_in    = cur_ff.x1;
               py_in    = cur_ff.y1;
               last_in  = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // table read issued at the low TBL_AW bits of the running position
            pos_in   = pos_ff + step_ff;
            state_in = ST_JIT;
         end
         ST_JIT: begin
            jit_in   = trd_vld_ff ? trd_ff : 8'sd0;
            dx_in    = cur_ff.x2 - cur_ff.x1;
            dy_in    = cur_ff.y2 - cur_ff.y1;
            state_in = ST_MULA;
         end
         ST_MULA: begin
            prod_in  = PROD_W'(dy_ff) * PROD_W'(jit_ff);
            state_in = ST_STA;
         end
         ST_STA: begin
            state_in = ST_WAITA;
         end
         ST_WAITA: begin
            if (div_rsp.done) begin
               qa_in    = div_rsp.quo;
               state_in = ST_MULB;
            end
         end
         ST_MULB: begin
            prod_in  = PROD_W'(dx_ff) * PROD_W'(jit_ff);
            state_in = ST_STB;
         end
         ST_STB: begin
            state_in = ST_WAITB;
         end
         ST_WAITB: begin
            if (div_rsp.done) begin
               qb_in    = div_rsp.quo;
               state_in = ST_MID;
            end
         end
         ST_MID: begin
            if (cur_ff.lvl >= LVL_W'(2)) begin
               // right half waits on the stack, left half goes on
               push       = 1'b1;
               sp_in      = sp_ff + 1'b1;
               cur_in.x2  = mx;
               cur_in.y2  = my;
               cur_in.lvl = cur_ff.lvl - 1'b1;
               state_in   = ST_READ;
            end else begin
               // leaf keeps its midpoint in the start slot
               cur_in.x1 = mx;
               cur_in.y1 = my;
               state_in  = ST_EMID;
            end
         end
         ST_EMID: begin
            if (out_free) begin
               emit     = 1'b1;
               kind_in  = KIND_LINE;
               px_in    = cur_ff.x1;
               py_in    = cur_ff.y1;
               last_in  = 1'b0;
               state_in = ST_EEND;
            end
         end
         ST_EEND: begin
            if (out_free) begin
               emit    = 1'b1;
               kind_in = KIND_LINE;
               px_in   = cur_ff.x2;
               py_in   = cur_ff.y2;
               last_in = (sp_ff == '0);
               if (sp_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  cur_in   = stack_ff[sp_dec[STK_AW-1:0]];
                  sp_in    = sp_dec;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff <= step_in;
      den_ff  <= den_in;
      cur_ff  <= cur_in;
      jit_ff  <= jit_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      prod_ff <= prod_in;
      qa_ff   <= qa_in;
      qb_ff   <= qb_in;
      kind_ff <= kind_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      last_ff <= last_in;
   end

   // segment stack, right halves pending
   always_ff @(posedge clock) begin
      if (push) begin
         stack_ff[sp_ff[STK_AW-1:0]] <= '{x1: mx, y1: my, x2: cur_ff.x2, y2: cur_ff.y2,
                                          lvl: cur_ff.lvl - 1'b1};
      end
   end

   // jitter table memory, written by load transactions
   always_ff @(posedge clock) begin
      if (req_take && (req_command == CMD_LOAD)) begin
         table_mem[req_table_index] <= req_table_value;
      end
      trd_ff <= table_mem[pos_ff[TBL_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tvld_ff    <= '0;
         trd_vld_ff <= 1'b0;
      end else begin
         if (req_take && (req_command == CMD_LOAD)) begin
            tvld_ff[req_table_index] <= 1'b1;
         end
         trd_vld_ff <= tvld_ff[pos_ff[TBL_AW-1:0]];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_kind = kind_ff;
   assign rsp_point_x    = px_ff;
   assign rsp_point_y    = py_ff;
   assign rsp_last       = last_ff;

   // divider only answers while the sequencer waits for it
   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_WAITA) || (state_ff == ST_WAITB))
      else $error("divider result arrived outside a wait state");

   // a split never overruns the segment stack
   a_stack_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MID) && (cur_ff.lvl >= LVL_W'(2)) |-> (sp_ff < SP_W'(STK_D)))
      else $error("segment stack overflow");

   // the final endpoint of a draw returns the sequencer to idle
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EEND) && out_free && (sp_ff == '0) |=> (state_ff == ST_IDLE) && rsp_last)
      else $error("draw did not close after its final point");

endmodule

>>> design/mdl_div.sv
// restoring divider, one quotient bit per cycle, signed result wrapped to 16 bits
module mdl_div (
   input  logic                clock,
   input  logic                reset,
   input  mdl_pkg::div_req_type req,
   output mdl_pkg::div_rsp_type rsp
);
   import mdl_pkg::*;

   localparam int CNT_W = $clog2(MAG_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           ge;

   always_comb begin
      trial = {rem_ff, quo_ff[MAG_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = trial >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.mag;
         den_in  = req.den;
         neg_in  = req.neg;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[MAG_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      rsp.done = done_ff;
      rsp.quo  = neg_ff ? -$signed(quo_ff[COORD_W-1:0]) : $signed(quo_ff[COORD_W-1:0]);
   end

endmodule
